// ----- hdl/alle_pkg.sv -----
package alle_pkg;

    localparam int NODES  = 64;
    localparam int NODE_W = $clog2(NODES);
    localparam int ADDR_W = 6;
    localparam int VAL_W  = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int FREE_W = 7;
    localparam int CNT_W  = $clog2(NODES);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [ADDR_W:0]   NODES_A  = (ADDR_W + 1)'(NODES);
    localparam logic [FREE_W-1:0] NODES_F  = FREE_W'(NODES);
    localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(NODES - 2);

    localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERASE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRAVERSE = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_ERASE,
        OP_TRAVERSE
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        t_op                     op;
        logic [ADDR_W-1:0]       pos;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] node_value;
        logic [ADDR_W-1:0]       node_address;
        t_status                 status;
        logic                    last;
    } t_res;

endpackage

// ----- hdl/alle_if.sv -----
interface alle_cmd_if import alle_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [ADDR_W-1:0]       position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

interface alle_res_if import alle_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] node_value;
    logic [ADDR_W-1:0]       node_address;
    logic [STAT_W-1:0]       status;
    logic                    last;

    modport source (output valid, node_value, node_address, status, last, input ready);
    modport sink   (input valid, node_value, node_address, status, last, output ready);
endinterface

// ----- hdl/array_linked_list_engine.sv -----
// Port    Dir  Beat carries
// ------  ---  ----------------------------------------------------
// i_cmd   in   kind, position, value (one command per beat)
// o_res   out  node_value, node_address, status, last (one result per beat)
//
// Insert steps through S_INS_A and S_INS_B, erase through S_ERS_WR, traverse through
// S_TRV_HEAD and then S_TRV_EMIT per listed node, as each node memory has a single
// write and read port; each command first sits in the two-entry command queue.
// Reset clears the link valid bits, live marks and allocator.
// A stalled o_res holds the back end; the queue keeps taking commands until full.
module array_linked_list_engine import alle_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    alle_cmd_if.sink     i_cmd,
    alle_res_if.source   o_res
);

    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    alle_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    alle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_fault_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.status != ST_OK) |-> o_res.last)
        else $error("non-ok result without last");

    a_empty_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.status == ST_EMPTY || o_res.status == ST_FULL)
        |-> (o_res.node_address == '0) && (o_res.node_value == '0))
        else $error("empty or full result carries data");

endmodule

// ----- hdl/alle_front.sv -----
module alle_front import alle_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    alle_cmd_if.sink     i_cmd,
    output logic         o_q_valid,
    output t_cmd         o_q_cmd,
    input  logic         i_q_pop
);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              known;
    logic              push;
    t_op               op;
    t_cmd              cmd;

    always_comb begin
        known = 1'b1;
        op    = OP_INSERT;
        case (i_cmd.kind)
            KIND_INSERT:   op = OP_INSERT;
            KIND_ERASE:    op = OP_ERASE;
            KIND_TRAVERSE: op = OP_TRAVERSE;
            default:       known = 1'b0;
        endcase
    end

    assign i_cmd.ready = (r_cnt != QCNT_W'(QDEPTH));
    // drop unused kinds at the door
    assign push        = i_cmd.valid && i_cmd.ready && known;
    assign cmd         = '{op: op, pos: i_cmd.position, value: i_cmd.value};
    assign n_cnt       = r_cnt + QCNT_W'(push) - QCNT_W'(i_q_pop);

    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wp] <= cmd;
    end

endmodule

// ----- hdl/alle_back.sv -----
module alle_back import alle_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_cmd         i_q_cmd,
    output logic         o_q_pop,
    alle_res_if.source   o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_A,
        S_INS_B,
        S_ERS_WR,
        S_TRV_HEAD,
        S_TRV_EMIT
    } t_state;

    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_pos, n_pos;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [ADDR_W-1:0]       r_succ, n_succ;
    logic [ADDR_W-1:0]       r_cur, n_cur;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [FREE_W-1:0]       r_free, n_free;
    logic [NODES-1:0]        r_live, n_live;
    logic [NODES-1:0]        r_next_ok, n_next_ok;
    logic                    r_ovalid, n_ovalid;
    t_res                    r_ores, n_ores;

    logic signed [VAL_W-1:0] r_vmem [NODES];
    logic [ADDR_W-1:0]       r_nmem [NODES];
    logic [ADDR_W-1:0]       r_pmem [NODES];
    logic signed [VAL_W-1:0] r_vq;
    logic [ADDR_W-1:0]       r_nq;
    logic                    r_nq_ok;
    logic [ADDR_W-1:0]       r_pq;

    logic                    v_we, v_re;
    logic [NODE_W-1:0]       v_wa, v_ra;
    logic signed [VAL_W-1:0] v_wd;
    logic                    nx_we, nx_re;
    logic [NODE_W-1:0]       nx_wa, nx_ra;
    logic [ADDR_W-1:0]       nx_wd;
    logic                    pv_we, pv_re;
    logic [NODE_W-1:0]       pv_wa, pv_ra;
    logic [ADDR_W-1:0]       pv_wd;

    logic                    out_free;
    logic [NODE_W-1:0]       pos_idx;
    logic                    in_rng;
    logic [ADDR_W-1:0]       next_rd;
    logic [NODE_W-1:0]       fresh;
    logic                    trv_end;

    assign out_free = !r_ovalid || o_res.ready;
    assign pos_idx  = i_q_cmd.pos[NODE_W-1:0];
    assign in_rng   = ({1'b0, i_q_cmd.pos} < NODES_A);
    assign next_rd  = r_nq_ok ? r_nq : '0;
    assign fresh    = r_free[NODE_W-1:0];
    assign trv_end  = (next_rd == '0) || (r_cnt == LAST_CNT);

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_val     = r_val;
        n_succ    = r_succ;
        n_cur     = r_cur;
        n_cnt     = r_cnt;
        n_free    = r_free;
        n_live    = r_live;
        n_next_ok = r_next_ok;
        n_ovalid  = r_ovalid && !o_res.ready;
        n_ores    = r_ores;
        o_q_pop   = 1'b0;
        v_we  = 1'b0; v_wa  = '0; v_wd  = '0; v_re  = 1'b0; v_ra  = '0;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_re = 1'b0; nx_ra = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_re = 1'b0; pv_ra = '0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    n_pos   = i_q_cmd.pos;
                    n_val   = i_q_cmd.value;
                    case (i_q_cmd.op)
                        OP_INSERT: begin
                            if (!(in_rng && (i_q_cmd.pos == '0 || r_live[pos_idx]))) begin
                                n_ovalid = 1'b1;
                                n_ores   = '{node_value: '0, node_address: i_q_cmd.pos,
                                             status: ST_INVALID, last: 1'b1};
                            end else if (r_free >= NODES_F) begin
                                n_ovalid = 1'b1;
                                n_ores   = '{node_value: '0, node_address: '0,
                                             status: ST_FULL, last: 1'b1};
                            end else begin
                                nx_re   = 1'b1;
                                nx_ra   = pos_idx;
                                n_state = S_INS_A;
                            end
                        end
                        OP_ERASE: begin
                            if (i_q_cmd.pos == '0 || !in_rng || !r_live[pos_idx]) begin
                                n_ovalid = 1'b1;
                                n_ores   = '{node_value: '0, node_address: i_q_cmd.pos,
                                             status: ST_INVALID, last: 1'b1};
                            end else begin
                                nx_re   = 1'b1;
                                nx_ra   = pos_idx;
                                pv_re   = 1'b1;
                                pv_ra   = pos_idx;
                                n_state = S_ERS_WR;
                            end
                        end
                        OP_TRAVERSE: begin
                            nx_re   = 1'b1;
                            nx_ra   = '0;
                            n_cnt   = '0;
                            n_state = S_TRV_HEAD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_A: begin
                v_we  = 1'b1;
                v_wa  = fresh;
                v_wd  = r_val;
                nx_we = 1'b1;
                nx_wa = fresh;
                nx_wd = next_rd;
                pv_we = 1'b1;
                pv_wa = fresh;
                pv_wd = r_pos;
                n_live[fresh] = 1'b1;
                n_succ  = next_rd;
                n_state = S_INS_B;
            end
            S_INS_B: begin
                if (out_free) begin
                    nx_we = 1'b1;
                    nx_wa = r_pos[NODE_W-1:0];
                    nx_wd = r_free[ADDR_W-1:0];
                    if (r_succ != '0) begin
                        pv_we = 1'b1;
                        pv_wa = r_succ[NODE_W-1:0];
                        pv_wd = r_free[ADDR_W-1:0];
                    end
                    n_free   = r_free + 1'b1;
                    n_ovalid = 1'b1;
                    n_ores   = '{node_value: '0, node_address: r_free[ADDR_W-1:0],
                                 status: ST_OK, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_ERS_WR: begin
                if (out_free) begin
                    nx_we = 1'b1;
                    nx_wa = r_pq[NODE_W-1:0];
                    nx_wd = next_rd;
                    if (next_rd != '0) begin
                        pv_we = 1'b1;
                        pv_wa = next_rd[NODE_W-1:0];
                        pv_wd = r_pq;
                    end
                    n_live[r_pos[NODE_W-1:0]] = 1'b0;
                    n_ovalid = 1'b1;
                    n_ores   = '{node_value: '0, node_address: r_pos,
                                 status: ST_OK, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_TRV_HEAD: begin
                if (next_rd == '0) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_ores   = '{node_value: '0, node_address: '0,
                                     status: ST_EMPTY, last: 1'b1};
                        n_state  = S_IDLE;
                    end
                end else begin
                    nx_re   = 1'b1;
                    nx_ra   = next_rd[NODE_W-1:0];
                    v_re    = 1'b1;
                    v_ra    = next_rd[NODE_W-1:0];
                    n_cur   = next_rd;
                    n_state = S_TRV_EMIT;
                end
            end
            S_TRV_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ores   = '{node_value: r_vq, node_address: r_cur,
                                 status: ST_OK, last: trv_end};
                    if (trv_end) begin
                        n_state = S_IDLE;
                    end else begin
                        nx_re = 1'b1;
                        nx_ra = next_rd[NODE_W-1:0];
                        v_re  = 1'b1;
                        v_ra  = next_rd[NODE_W-1:0];
                        n_cur = next_rd;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (nx_we) n_next_ok[nx_wa] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_free    <= FREE_W'(1);
            r_live    <= '0;
            r_next_ok <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_live    <= n_live;
            r_next_ok <= n_next_ok;
            r_ovalid  <= n_ovalid;
            r_ores    <= n_ores;
            r_pos     <= n_pos;
            r_val     <= n_val;
            r_succ    <= n_succ;
            r_cur     <= n_cur;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_vmem[v_wa] <= v_wd;
        if (v_re) r_vq <= r_vmem[v_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) r_nmem[nx_wa] <= nx_wd;
        if (nx_re) begin
            r_nq    <= r_nmem[nx_ra];
            r_nq_ok <= r_next_ok[nx_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) r_pmem[pv_wa] <= pv_wd;
        if (pv_re) r_pq <= r_pmem[pv_ra];
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.node_value   = r_ores.node_value;
    assign o_res.node_address = r_ores.node_address;
    assign o_res.status       = r_ores.status;
    assign o_res.last         = r_ores.last;

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import alle_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int N_RANDOM = 407;
    localparam int N_QUIET  = 60;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] pos;
        logic [VAL_W-1:0]  value;
        logic              typed;
        t_res              want;
    } t_stim_row;

    localparam t_res NO_RES = '0;

    t_stim_row directed_rows [23] = '{
        '{KIND_TRAVERSE, 6'd0,  32'h0000_0000, 1'b1, '{32'sd0, 6'd0,  ST_EMPTY,   1'b1}},
        '{KIND_ERASE,    6'd0,  32'h0000_0000, 1'b1, '{32'sd0, 6'd0,  ST_INVALID, 1'b1}},
        '{KIND_ERASE,    6'd5,  32'h0000_0000, 1'b1, '{32'sd0, 6'd5,  ST_INVALID, 1'b1}},
        '{KIND_INSERT,   6'd7,  32'h0000_1234, 1'b1, '{32'sd0, 6'd7,  ST_INVALID, 1'b1}},
        '{KIND_INSERT,   6'd0,  32'h7fff_ffff, 1'b1, '{32'sd0, 6'd1,  ST_OK,      1'b1}},
        '{KIND_INSERT,   6'd1,  32'h8000_0000, 1'b1, '{32'sd0, 6'd2,  ST_OK,      1'b1}},
        '{KIND_INSERT,   6'd0,  32'hffff_ffff, 1'b1, '{32'sd0, 6'd3,  ST_OK,      1'b1}},
        '{KIND_INSERT,   6'd2,  32'h0000_0000, 1'b1, '{32'sd0, 6'd4,  ST_OK,      1'b1}},
        '{KIND_TRAVERSE, 6'd0,  32'h0000_0000, 1'b0, NO_RES},
        '{KIND_ERASE,    6'd2,  32'h0000_0000, 1'b1, '{32'sd0, 6'd2,  ST_OK,      1'b1}},
        '{KIND_ERASE,    6'd2,  32'h0000_0000, 1'b1, '{32'sd0, 6'd2,  ST_INVALID, 1'b1}},
        '{KIND_INSERT,   6'd2,  32'h0000_0bad, 1'b1, '{32'sd0, 6'd2,  ST_INVALID, 1'b1}},
        '{KIND_UNUSED,   6'd63, 32'ha5a5_a5a5, 1'b0, NO_RES},
        '{KIND_TRAVERSE, 6'd0,  32'h0000_0000, 1'b0, NO_RES},
        '{KIND_ERASE,    6'd3,  32'h0000_0000, 1'b1, '{32'sd0, 6'd3,  ST_OK,      1'b1}},
        '{KIND_ERASE,    6'd63, 32'h0000_0000, 1'b1, '{32'sd0, 6'd63, ST_INVALID, 1'b1}},
        '{KIND_INSERT,   6'd63, 32'h0000_0001, 1'b1, '{32'sd0, 6'd63, ST_INVALID, 1'b1}},
        '{KIND_TRAVERSE, 6'd0,  32'h0000_0000, 1'b0, NO_RES},
        '{KIND_INSERT,   6'd4,  32'h5555_5555, 1'b1, '{32'sd0, 6'd5,  ST_OK,      1'b1}},
        '{KIND_INSERT,   6'd0,  32'haaaa_aaaa, 1'b1, '{32'sd0, 6'd6,  ST_OK,      1'b1}},
        '{KIND_TRAVERSE, 6'd0,  32'h0000_0000, 1'b0, NO_RES},
        '{KIND_ERASE,    6'd5,  32'h0000_0000, 1'b1, '{32'sd0, 6'd5,  ST_OK,      1'b1}},
        '{KIND_TRAVERSE, 6'd0,  32'h0000_0000, 1'b0, NO_RES}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    alle_cmd_if cmd_bus ();
    alle_res_if res_bus ();

    array_linked_list_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    logic signed [VAL_W-1:0] m_value [NODES];
    logic [ADDR_W-1:0]       m_next  [NODES];
    logic [ADDR_W-1:0]       m_prev  [NODES];
    logic                    m_live  [NODES];
    logic [FREE_W-1:0]       m_free;

    t_res list_replies [$];
    t_res step_out [$];
    int   mismatch_count = 0;
    logic quiet = 1'b0;
    int   tx_calm = 0;
    int   rx_stall = 0;
    int   rx_calm = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_res res_of(logic signed [VAL_W-1:0] val, logic [ADDR_W-1:0] addr,
                                    t_status st, logic fin);
        t_res r;
        r.node_value   = val;
        r.node_address = addr;
        r.status       = st;
        r.last         = fin;
        return r;
    endfunction

    // advance the mirrored list by one command and collect its replies
    task automatic apply_list_cmd(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] pos,
                                  input logic signed [VAL_W-1:0] val);
        logic [ADDR_W-1:0] fresh;
        logic [ADDR_W-1:0] succ;
        logic [ADDR_W-1:0] prv;
        logic [ADDR_W-1:0] cur;
        int                count;
        logic              done;
        step_out.delete();
        case (kind)
            KIND_INSERT: begin
                if (pos != '0 && !m_live[pos]) begin
                    step_out.push_back(res_of('0, pos, ST_INVALID, 1'b1));
                end else if (m_free >= NODES_F) begin
                    step_out.push_back(res_of('0, '0, ST_FULL, 1'b1));
                end else begin
                    fresh          = m_free[ADDR_W-1:0];
                    succ           = m_next[pos];
                    m_value[fresh] = val;
                    m_next[fresh]  = succ;
                    m_prev[fresh]  = pos;
                    m_live[fresh]  = 1'b1;
                    m_next[pos]    = fresh;
                    if (succ != '0) m_prev[succ] = fresh;
                    m_free = m_free + 1'b1;
                    step_out.push_back(res_of('0, fresh, ST_OK, 1'b1));
                end
            end
            KIND_ERASE: begin
                if (pos == '0 || !m_live[pos]) begin
                    step_out.push_back(res_of('0, pos, ST_INVALID, 1'b1));
                end else begin
                    prv          = m_prev[pos];
                    succ         = m_next[pos];
                    m_next[prv]  = succ;
                    if (succ != '0) m_prev[succ] = prv;
                    m_live[pos]  = 1'b0;
                    step_out.push_back(res_of('0, pos, ST_OK, 1'b1));
                end
            end
            KIND_TRAVERSE: begin
                cur = m_next[0];
                if (cur == '0) begin
                    step_out.push_back(res_of('0, '0, ST_EMPTY, 1'b1));
                end else begin
                    count = 0;
                    done  = 1'b0;
                    while (!done) begin
                        succ = m_next[cur];
                        done = (succ == '0) || (count == NODES - 2);
                        step_out.push_back(res_of(m_value[cur], cur, ST_OK, done));
                        count++;
                        cur = succ;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [ADDR_W-1:0] pick_live();
        logic [ADDR_W-1:0] alive [$];
        for (int a = 1; a < NODES; a++) begin
            if (m_live[a]) alive.push_back(ADDR_W'(a));
        end
        if (alive.size() == 0) return '0;
        return alive[$urandom_range(0, alive.size() - 1)];
    endfunction

    task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
        $display("mismatch on %s: got %0h, want %0h", what, got, want);
        mismatch_count++;
    endtask

    // hold the command until it is taken, then predict
    task automatic send_list_cmd(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] val, input logic typed,
                                 input t_res typed_res);
        int gap;
        gap = 0;
        if (!quiet) begin
            if (tx_calm > 0) begin
                tx_calm--;
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: gap = $urandom_range(1, 13);
                    2: tx_calm = $urandom_range(10, 40);
                    default: begin
                    end
                endcase
            end
        end
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.kind     <= kind;
        cmd_bus.position <= pos;
        cmd_bus.value    <= val;
        do @(posedge i_clk); while (!cmd_bus.ready);
        apply_list_cmd(kind, pos, val);
        if (typed) begin
            list_replies.push_back(typed_res);
        end else begin
            foreach (step_out[n]) list_replies.push_back(step_out[n]);
        end
    endtask

    task automatic drain_replies();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (list_replies.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            res_bus.ready <= 1'b1;
        end else if (rx_stall > 1) begin
            rx_stall--;
            res_bus.ready <= 1'b0;
        end else if (rx_stall == 1) begin
            rx_stall = 0;
            res_bus.ready <= 1'b1;
        end else if (rx_calm > 0) begin
            rx_calm--;
            res_bus.ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    rx_stall = $urandom_range(1, 13);
                    res_bus.ready <= 1'b0;
                end
                1: begin
                    rx_calm = $urandom_range(20, 80);
                    res_bus.ready <= 1'b1;
                end
                default: res_bus.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (list_replies.size() == 0) begin
                flag_mismatch("beat with nothing due", res_bus.node_address, '0);
            end else begin
                want = list_replies.pop_front();
                if (res_bus.node_value !== want.node_value)
                    flag_mismatch("node_value", res_bus.node_value, want.node_value);
                if (res_bus.node_address !== want.node_address)
                    flag_mismatch("node_address", res_bus.node_address, want.node_address);
                if (res_bus.status !== want.status)
                    flag_mismatch("status", res_bus.status, want.status);
                if (res_bus.last !== want.last)
                    flag_mismatch("last", res_bus.last, want.last);
            end
        end
    end

    initial begin
        logic [KIND_W-1:0]       k;
        logic [ADDR_W-1:0]       p;
        logic signed [VAL_W-1:0] v;
        int                      roll;
        foreach (m_next[a]) begin
            m_value[a] = '0;
            m_next[a]  = '0;
            m_prev[a]  = '0;
            m_live[a]  = 1'b0;
        end
        m_free = FREE_W'(1);
        i_rst_n          <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.kind     <= KIND_INSERT;
        cmd_bus.position <= '0;
        cmd_bus.value    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_list_cmd(directed_rows[r].kind, directed_rows[r].pos, directed_rows[r].value,
                          directed_rows[r].typed, directed_rows[r].want);
        end
        drain_replies();

        for (int i = 0; i < N_RANDOM; i++) begin
            quiet = (i >= N_RANDOM - N_QUIET);
            if (i % 100 == 60) drain_replies();
            roll = $urandom_range(0, 99);
            v    = $urandom();
            p    = ADDR_W'($urandom_range(0, NODES - 1));
            if (m_free < NODES_F) begin
                if (roll < 55) begin
                    k = KIND_INSERT;
                    if (roll < 40) p = pick_live();
                    else if (roll < 45) p = '0;
                end else if (roll < 70) begin
                    k = KIND_ERASE;
                    if (roll < 66) p = pick_live();
                end else if (roll < 90) begin
                    k = KIND_TRAVERSE;
                end else if (roll < 95) begin
                    k = KIND_UNUSED;
                end else begin
                    k = KIND_W'($urandom_range(0, 3));
                end
            end else begin
                if (roll < 25) begin
                    k = KIND_INSERT;
                    if (roll < 15) p = pick_live();
                end else if (roll < 45) begin
                    k = KIND_ERASE;
                    if (roll < 40) p = pick_live();
                end else if (roll < 85) begin
                    k = KIND_TRAVERSE;
                end else if (roll < 90) begin
                    k = KIND_UNUSED;
                end else begin
                    k = KIND_W'($urandom_range(0, 3));
                end
            end
            send_list_cmd(k, p, v, 1'b0, NO_RES);
        end
        drain_replies();
        repeat (24) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
